// ----- src/pzdsw_pkg.sv -----
// ----------------------------------------------------------------------------
// pzdsw_pkg
// Shared constants for the palette zoom span writer: request action codes,
// result kinds, register indexes, register reset values and parameter defaults.
// ----------------------------------------------------------------------------
package pzdsw_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int COLOR_BITS_DEF    = 32;
  localparam int ADDRESS_BITS_DEF  = 24;

  localparam int ACTION_W    = 2;
  localparam int INDEX_W     = 8;
  localparam int COLOR_W     = 32;
  localparam int OUT_ADDR_W  = 24;
  localparam int SPAN_W      = 5;
  localparam int ZOOM_W      = 4;
  localparam int PITCH_W     = 12;
  localparam int BASE_W      = 24;
  localparam int SWIDTH_W    = 10;
  localparam int REPEAT_W    = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PIXEL = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FRAME = 2'd2;

  localparam logic KIND_SPAN   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_ZOOM         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_PITCH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_OFFSET  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FULL_REDRAW  = 3'd4;

  localparam logic [ZOOM_W-1:0]   ZOOM_RESET   = 4'd1;
  localparam logic [ZOOM_W-1:0]   ZOOM_MAX     = 4'd8;
  localparam logic [PITCH_W-1:0]  PITCH_RESET  = 12'd320;
  localparam logic [BASE_W-1:0]   BASE_RESET   = 24'd0;
  localparam logic [SWIDTH_W-1:0] SWIDTH_RESET = 10'd160;

endpackage

// ----- src/pzdsw_ram.sv -----
// ----------------------------------------------------------------------------
// pzdsw_ram
// Generic single-port synchronous RAM. Read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module pzdsw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- src/palette_zoom_dirty_span_writer.sv -----
// ----------------------------------------------------------------------------
// palette_zoom_dirty_span_writer
// Palette lookup span writer for an integer zoom scaler. Loads palette
// entries, turns changed source pixels (every pixel under full redraw) into
// span writes and reports a sticky dirty flag at end of frame.
//
//   channel   signals                              direction
//   in        in_valid / in_ready + request fields  sink
//   out       out_valid / out_ready + result fields source
//   cfg       cfg_write, cfg_index, cfg_data       sink, write only
//
// One request per cycle sustained while the output is not stalled; a result
// passes the registered palette read and then the output register.
// Counters and the dirty flag update at acceptance; the palette sits in a
// single-port RAM. The palette is not cleared by reset.
// A stalled output holds one result plus one in flight, then drops in_ready.
// ----------------------------------------------------------------------------
module palette_zoom_dirty_span_writer import pzdsw_pkg::*; #(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  parameter int COLOR_BITS    = COLOR_BITS_DEF,
  parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ACTION_W-1:0]    action,
  input  logic [INDEX_W-1:0]     current_index,
  input  logic [INDEX_W-1:0]     previous_index,
  input  logic [INDEX_W-1:0]     entry_index,
  input  logic [COLOR_W-1:0]     entry_color,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   kind,
  output logic [OUT_ADDR_W-1:0]  write_address,
  output logic [COLOR_W-1:0]     write_color,
  output logic [SPAN_W-1:0]      span_length,
  output logic                   frame_dirty
);

  localparam int IDX_BITS = $clog2(PALETTE_DEPTH);

  logic [ZOOM_W-1:0]       zoom;
  logic [PITCH_W-1:0]      screen_pitch;
  logic [BASE_W-1:0]       base_offset;
  logic [SWIDTH_W-1:0]     source_width;
  logic                    full_redraw;

  logic [SWIDTH_W-1:0]     column_count;
  logic [REPEAT_W-1:0]     row_repeat_count;
  logic [ADDRESS_BITS-1:0] row_offset;
  logic                    dirty_flag;

  logic                    s1_valid;
  logic                    s1_kind;
  logic [ADDRESS_BITS-1:0] s1_addr;
  logic [SPAN_W-1:0]       s1_len;
  logic                    s1_color_ok;
  logic                    s1_dirty;

  logic [ZOOM_W-1:0]       zoom_eff;
  logic [SPAN_W-1:0]       span_len;
  logic [14:0]             col_scaled;
  logic [ADDRESS_BITS-1:0] span_addr;
  logic                    accept;
  logic                    is_load;
  logic                    is_pixel;
  logic                    is_frame;
  logic                    emit_span;
  logic                    has_result;
  logic                    row_end;
  logic                    cur_in_range;
  logic                    load_in_range;
  logic                    s1_move;
  logic                    ram_we;
  logic                    ram_re;
  logic [IDX_BITS-1:0]     ram_addr;
  logic [COLOR_BITS-1:0]   ram_rdata;
  logic [REPEAT_W:0]       repeat_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      zoom         <= ZOOM_RESET;
      screen_pitch <= PITCH_RESET;
      base_offset  <= BASE_RESET;
      source_width <= SWIDTH_RESET;
      full_redraw  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ZOOM:         zoom         <= cfg_data[ZOOM_W-1:0];
        REG_SCREEN_PITCH: screen_pitch <= cfg_data[PITCH_W-1:0];
        REG_BASE_OFFSET:  base_offset  <= cfg_data[BASE_W-1:0];
        REG_SOURCE_WIDTH: source_width <= cfg_data[SWIDTH_W-1:0];
        REG_FULL_REDRAW:  full_redraw  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (zoom == '0) begin
      zoom_eff = ZOOM_RESET;
    end else if (zoom > ZOOM_MAX) begin
      zoom_eff = ZOOM_MAX;
    end else begin
      zoom_eff = zoom;
    end
  end

  assign span_len   = {zoom_eff, 1'b0};
  assign col_scaled = 15'(column_count) * 15'(span_len);
  assign span_addr  = ADDRESS_BITS'(base_offset) + row_offset + ADDRESS_BITS'(col_scaled);

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_load    = (action == ACT_LOAD);
  assign is_pixel   = (action == ACT_PIXEL);
  assign is_frame   = (action == ACT_FRAME);
  assign emit_span  = is_pixel && ((current_index != previous_index) || full_redraw);
  assign has_result = emit_span || is_frame;
  assign row_end    = ({1'b0, column_count} + 11'd1) >= {1'b0, source_width};
  assign repeat_inc = {1'b0, row_repeat_count} + 4'd1;

  assign cur_in_range  = {1'b0, current_index} < 9'(PALETTE_DEPTH);
  assign load_in_range = {1'b0, entry_index} < 9'(PALETTE_DEPTH);

  assign ram_we   = accept && is_load && load_in_range;
  assign ram_re   = accept && emit_span;
  assign ram_addr = is_load ? entry_index[IDX_BITS-1:0] : current_index[IDX_BITS-1:0];

  pzdsw_ram #(
    .WIDTH (COLOR_BITS),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (entry_color[COLOR_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // advance counters at acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count     <= '0;
      row_repeat_count <= '0;
      row_offset       <= '0;
      dirty_flag       <= 1'b0;
    end else if (accept) begin
      if (is_pixel) begin
        if (emit_span) begin
          dirty_flag <= 1'b1;
        end
        if (row_end) begin
          column_count <= '0;
          row_offset   <= row_offset + ADDRESS_BITS'(screen_pitch);
          if (repeat_inc >= zoom_eff[REPEAT_W:0]) begin
            row_repeat_count <= '0;
          end else begin
            row_repeat_count <= repeat_inc[REPEAT_W-1:0];
          end
        end else begin
          column_count <= column_count + 10'd1;
        end
      end else if (is_frame) begin
        column_count     <= '0;
        row_repeat_count <= '0;
        row_offset       <= '0;
        dirty_flag       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= has_result;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      s1_kind     <= is_frame ? KIND_STATUS : KIND_SPAN;
      s1_addr     <= is_frame ? '0 : span_addr;
      s1_len      <= is_frame ? '0 : span_len;
      s1_color_ok <= emit_span && cur_in_range;
      s1_dirty    <= is_frame ? dirty_flag : 1'b1;
    end
    if (s1_move) begin
      kind          <= s1_kind;
      write_address <= OUT_ADDR_W'(s1_addr);
      write_color   <= s1_color_ok ? COLOR_W'(ram_rdata) : '0;
      span_length   <= s1_len;
      frame_dirty   <= s1_dirty;
    end
  end

endmodule

// ----- src/pzdsw_checker.sv -----
// ----------------------------------------------------------------------------
// pzdsw_checker
// Port-level checks for the palette zoom span writer, bound to the top level.
// ----------------------------------------------------------------------------
module pzdsw_checker import pzdsw_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  kind,
  input logic [OUT_ADDR_W-1:0] write_address,
  input logic [COLOR_W-1:0]    write_color,
  input logic [SPAN_W-1:0]     span_length,
  input logic                  frame_dirty
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(write_address) &&
      $stable(write_color) && $stable(kind) && $stable(frame_dirty))
    else $error("stalled result changed");

  a_span_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_SPAN |-> frame_dirty && !span_length[0] &&
      span_length >= 5'd2 && span_length <= 5'd16)
    else $error("span write with bad length or clear dirty flag");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_STATUS |-> write_address == '0 &&
      write_color == '0 && span_length == '0)
    else $error("frame status with nonzero span fields");

  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a request two cycles earlier");

endmodule

bind palette_zoom_dirty_span_writer pzdsw_checker u_pzdsw_checker (.*);

// ----- tb/sv/tb_palette_zoom_dirty_span_writer.sv -----
// ----------------------------------------------------------------------------
// tb_palette_zoom_dirty_span_writer
// Self-checking bench for the palette zoom span writer. A scoreboard class
// tracks palette, address counters and dirty flag, predicts every span write
// and frame status, and matches them in order against the result channel.
// Traffic is a short directed set followed by random frames over a series
// of register settings, with sender gaps and receiver stalls varied by phase.
// ----------------------------------------------------------------------------
import pzdsw_pkg::*;

localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

typedef struct {
  logic [ACTION_W-1:0] act;
  logic [INDEX_W-1:0]  cur;
  logic [INDEX_W-1:0]  prev;
  logic [INDEX_W-1:0]  eidx;
  logic [COLOR_W-1:0]  ecol;
} pixel_request_t;

typedef struct packed {
  logic                  kind;
  logic [OUT_ADDR_W-1:0] addr;
  logic [COLOR_W-1:0]    color;
  logic [SPAN_W-1:0]     span;
  logic                  dirty;
} span_result_t;

class span_ledger;
  span_result_t          owed[$];
  logic [COLOR_W-1:0]    colors[PALETTE_DEPTH_DEF];
  logic [ZOOM_W-1:0]     zoom_r;
  logic [PITCH_W-1:0]    pitch_r;
  logic [BASE_W-1:0]     base_r;
  logic [SWIDTH_W-1:0]   width_r;
  logic                  redraw_r;
  logic [SWIDTH_W-1:0]   column;
  int                    repeat_line;
  logic [OUT_ADDR_W-1:0] row_base;
  logic                  dirty;
  int                    errors;
  int                    printed;

  function new();
    zoom_r      = ZOOM_RESET;
    pitch_r     = PITCH_RESET;
    base_r      = BASE_RESET;
    width_r     = SWIDTH_RESET;
    redraw_r    = 1'b0;
    column      = '0;
    repeat_line = 0;
    row_base    = '0;
    dirty       = 1'b0;
    errors      = 0;
    printed     = 0;
  endfunction

  task report(string msg);
    errors++;
    if (printed < 100) begin
      $display("ERROR @%0t: %s", $realtime, msg);
      printed++;
    end
  endtask

  function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ZOOM:         zoom_r   = data[ZOOM_W-1:0];
      REG_SCREEN_PITCH: pitch_r  = data[PITCH_W-1:0];
      REG_BASE_OFFSET:  base_r   = data[BASE_W-1:0];
      REG_SOURCE_WIDTH: width_r  = data[SWIDTH_W-1:0];
      REG_FULL_REDRAW:  redraw_r = data[0];
      default: ;
    endcase
  endfunction

  function void accept_request(pixel_request_t r);
    int           z;
    logic [31:0]  offs;
    logic [31:0]  span_tmp;
    span_result_t res;
    z = (zoom_r == 0) ? 1 : ((zoom_r > ZOOM_MAX) ? int'(ZOOM_MAX) : int'(zoom_r));
    case (r.act)
      ACT_LOAD: colors[r.eidx] = r.ecol;
      ACT_PIXEL: begin
        if (r.cur != r.prev || redraw_r) begin
          offs      = int'(column) * 2 * z;
          span_tmp  = 2 * z;
          res.kind  = KIND_SPAN;
          res.addr  = base_r + row_base + offs[OUT_ADDR_W-1:0];
          res.color = colors[r.cur];
          res.span  = span_tmp[SPAN_W-1:0];
          res.dirty = 1'b1;
          dirty     = 1'b1;
          owed.push_back(res);
        end
        if (int'(column) + 1 >= int'(width_r)) begin
          column      = '0;
          row_base    = row_base + pitch_r;
          repeat_line = repeat_line + 1;
          if (repeat_line >= z) repeat_line = 0;
        end else begin
          column = column + 1'b1;
        end
      end
      ACT_FRAME: begin
        res.kind    = KIND_STATUS;
        res.addr    = '0;
        res.color   = '0;
        res.span    = '0;
        res.dirty   = dirty;
        owed.push_back(res);
        dirty       = 1'b0;
        column      = '0;
        repeat_line = 0;
        row_base    = '0;
      end
      default: ;
    endcase
  endfunction

  task compare_result(span_result_t got);
    span_result_t want;
    if (owed.size() == 0) begin
      report($sformatf("result with nothing pending: kind=%0d addr=%h color=%h",
                       got.kind, got.addr, got.color));
      return;
    end
    want = owed.pop_front();
    if (got.kind !== want.kind)
      report($sformatf("kind %0d, want %0d", got.kind, want.kind));
    if (got.addr !== want.addr)
      report($sformatf("write_address %h, want %h", got.addr, want.addr));
    if (got.color !== want.color)
      report($sformatf("write_color %h, want %h", got.color, want.color));
    if (got.span !== want.span)
      report($sformatf("span_length %0d, want %0d", got.span, want.span));
    if (got.dirty !== want.dirty)
      report($sformatf("frame_dirty %0d, want %0d", got.dirty, want.dirty));
  endtask

  task flush_check();
    if (owed.size() != 0)
      report($sformatf("%0d results never arrived", owed.size()));
  endtask
endclass

module tb_palette_zoom_dirty_span_writer;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [ACTION_W-1:0]    action = '0;
  logic [INDEX_W-1:0]     current_index = '0;
  logic [INDEX_W-1:0]     previous_index = '0;
  logic [INDEX_W-1:0]     entry_index = '0;
  logic [COLOR_W-1:0]     entry_color = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   kind;
  logic [OUT_ADDR_W-1:0]  write_address;
  logic [COLOR_W-1:0]     write_color;
  logic [SPAN_W-1:0]      span_length;
  logic                   frame_dirty;

  span_ledger     ledger;
  pixel_request_t request_fifo[$];
  pixel_request_t shown;
  int             send_gap_pct = 0;
  int             stall_pct = 0;
  int             items_queued = 0;
  bit             is_loaded[PALETTE_DEPTH_DEF];
  logic [INDEX_W-1:0] loaded_list[$];

  palette_zoom_dirty_span_writer uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .current_index(current_index), .previous_index(previous_index),
    .entry_index(entry_index), .entry_color(entry_color),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .write_address(write_address), .write_color(write_color),
    .span_length(span_length), .frame_dirty(frame_dirty)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        ledger.compare_result({kind, write_address, write_color, span_length, frame_dirty});
      if (in_valid && in_ready)
        ledger.accept_request(shown);
      if (!in_valid || in_ready) begin
        if (request_fifo.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          shown = request_fifo.pop_front();
          in_valid       <= 1'b1;
          action         <= shown.act;
          current_index  <= shown.cur;
          previous_index <= shown.prev;
          entry_index    <= shown.eidx;
          entry_color    <= shown.ecol;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic logic [INDEX_W-1:0] pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  function automatic void queue_load(logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] color);
    pixel_request_t r;
    r.act  = ACT_LOAD;
    r.cur  = idx;
    r.prev = INDEX_W'($urandom_range(0, 255));
    r.eidx = idx;
    r.ecol = color;
    request_fifo.push_back(r);
    if (!is_loaded[idx]) begin
      is_loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
    items_queued++;
  endfunction

  function automatic void queue_pixel(logic [INDEX_W-1:0] cur, logic [INDEX_W-1:0] prev);
    pixel_request_t r;
    r.act  = ACT_PIXEL;
    r.cur  = cur;
    r.prev = prev;
    r.eidx = INDEX_W'($urandom_range(0, 255));
    r.ecol = $urandom;
    request_fifo.push_back(r);
    items_queued++;
  endfunction

  function automatic void queue_other(logic [ACTION_W-1:0] act);
    pixel_request_t r;
    r.act  = act;
    r.cur  = pick_loaded();
    r.prev = INDEX_W'($urandom_range(0, 255));
    r.eidx = INDEX_W'($urandom_range(0, 255));
    r.ecol = $urandom;
    request_fifo.push_back(r);
    if (act != ACT_UNUSED) items_queued++;
  endfunction

  task automatic wait_idle();
    while (request_fifo.size() != 0 || in_valid || ledger.owed.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, int width, int value, bit junk);
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] data;
    mask = (width >= CFG_DATA_W) ? '1 : CFG_DATA_W'((1 << width) - 1);
    data = CFG_DATA_W'(value) & mask;
    if (junk) data = data | (CFG_DATA_W'($urandom) & ~mask);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    ledger.set_register(idx, data);
  endtask

  task automatic run_phase(int mode, int z, int pitch, int base, int sw, int redraw,
                           bit junk, int quota);
    int z_eff;
    int sw_eff;
    int frame_len;
    int roll;
    logic [INDEX_W-1:0] cur;
    case (mode)
      0: begin send_gap_pct = 0;  stall_pct = 0;  end
      1: begin send_gap_pct = 88; stall_pct = 0;  end
      2: begin send_gap_pct = 0;  stall_pct = 88; end
      default: begin send_gap_pct = 7; stall_pct = 7; end
    endcase
    write_register(REG_ZOOM, ZOOM_W, z, junk);
    write_register(REG_SCREEN_PITCH, PITCH_W, pitch, junk);
    write_register(REG_BASE_OFFSET, BASE_W, base, junk);
    write_register(REG_SOURCE_WIDTH, SWIDTH_W, sw, junk);
    write_register(REG_FULL_REDRAW, 1, redraw, junk);
    @(posedge clk);
    cfg_write <= 1'b0;
    z_eff  = (ledger.zoom_r == 0) ? 1 : ((ledger.zoom_r > ZOOM_MAX) ? 8 : int'(ledger.zoom_r));
    sw_eff = (ledger.width_r == 0) ? 1 : int'(ledger.width_r);
    items_queued = 0;
    while (items_queued < quota) begin
      frame_len = sw_eff * z_eff * $urandom_range(1, 2);
      if (frame_len > 48 || $urandom_range(0, 99) < 15) frame_len = $urandom_range(1, 48);
      for (int k = 0; k < frame_len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          queue_load(INDEX_W'($urandom_range(0, 255)), $urandom);
        end else if (roll < 7) begin
          queue_other(ACT_UNUSED);
        end else begin
          cur = pick_loaded();
          queue_pixel(cur, ($urandom_range(0, 1) == 0) ? cur :
                           INDEX_W'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 99) < 90) queue_other(ACT_FRAME);
    end
    wait_idle();
  endtask

  initial begin
    int z;
    int sw;
    ledger = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_load(8'h00, 32'h0000_0000);
    queue_load(8'hFF, 32'hFFFF_FFFF);
    queue_load(8'hAA, 32'hAAAA_AAAA);
    queue_load(8'h55, 32'h5555_5555);
    queue_load(8'h01, 32'h1234_5678);
    queue_pixel(8'h00, 8'h00);
    queue_pixel(8'hFF, 8'h00);
    queue_pixel(8'hAA, 8'h55);
    queue_pixel(8'h55, 8'hAA);
    queue_pixel(8'h00, 8'hFF);
    queue_pixel(8'h01, 8'h01);
    queue_other(ACT_UNUSED);
    queue_other(ACT_FRAME);
    queue_other(ACT_FRAME);
    queue_pixel(8'hFF, 8'hFF);
    queue_other(ACT_FRAME);
    wait_idle();

    run_phase(0, 0, 1, 0, 0, 1, 1'b0, 90);
    run_phase(1, 8, 4095, 24'hFFFF00, 3, 0, 1'b0, 90);
    run_phase(2, 15, 4095, 24'hFFFFFF, 1023, 1, 1'b1, 90);
    run_phase(3, 1, 0, 0, 1, 0, 1'b0, 90);
    for (int p = 4; p < 10; p++) begin
      if ($urandom_range(0, 99) < 15)
        z = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 15);
      else
        z = $urandom_range(1, 8);
      sw = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 8) : $urandom_range(9, 1023);
      run_phase(p % 4, z, $urandom_range(0, 4095), $urandom_range(0, 24'hFFFFFF), sw,
                $urandom_range(0, 1), ($urandom_range(0, 99) < 30), 90);
    end

    repeat (16) @(posedge clk);
    ledger.flush_check();
    if (ledger.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
